// File: rtl/krg_pkg.sv
// Shared types, constants and helpers for the keystroke rate guard.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package krg_pkg;

   localparam int unsigned WINDOW_DEF     = 32;
   localparam int unsigned MS_PER_MIN     = 60000;
   localparam int unsigned CHARS_PER_WORD = 5;
   localparam int unsigned TIME_W         = 32;
   localparam int unsigned WPM_W          = 19;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam int unsigned CSR_ADDR_W     = 3;
   localparam logic [WPM_W-1:0] WPM_MAX   = '1;
   localparam logic [WPM_W-1:0] WPM_RESET = 19'd200;

   // request codes; code 3 is reserved and ignored
   typedef enum logic [1:0] {
      REQ_KEY   = 2'd0,
      REQ_START = 2'd1,
      REQ_END   = 2'd2
   } req_code_type;

   // register index, taken from paddr[2]
   typedef enum logic {
      CSR_MAX_WPM = 1'b0
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic             rate_valid;
      logic [WPM_W-1:0] rate_wpm;
      logic             reject;
      logic             session_active;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // bits needed for the constant dividend WINDOW*60000
   function automatic int unsigned num_width(input int unsigned window);
      return $clog2(window * MS_PER_MIN + 1);
   endfunction

endpackage

`default_nettype wire

// File: rtl/krg_if.sv
// Valid/ready channel interfaces for the request and result transfers.
// Depends on krg_pkg for field widths.
`default_nettype none

interface krg_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    req_type;
   logic [krg_pkg::TIME_W-1:0]    key_time_ms;

   modport source (output valid, output req_type, output key_time_ms, input ready);
   modport sink   (input valid, input req_type, input key_time_ms, output ready);
endinterface

interface krg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          rate_valid;
   logic [krg_pkg::WPM_W-1:0]     rate_wpm;
   logic                          reject;
   logic                          session_active;

   modport source (output valid, output rate_valid, output rate_wpm, output reject,
                   output session_active, input ready);
   modport sink   (input valid, input rate_valid, input rate_wpm, input reject,
                   input session_active, output ready);
endinterface

`default_nettype wire

// File: rtl/keystroke_rate_guard.sv
// Keystroke rate guard: usage
//   req_chan carries one transfer per item: req_type (0 keystroke, 1 session
//   start, 2 session end, 3 ignored) and key_time_ms. rsp_chan returns exactly
//   one transfer per item: rate_valid, rate_wpm, reject, session_active.
//   csr_* is an APB-style port holding max_human_wpm at byte address 0.
// Sequence
//   One item in flight. Start, end, ignored and non-full keystrokes pass
//   from the request transfer through the result register into the output
//   register. A full-window keystroke first reads the oldest time from the
//   ring, then runs the bit-serial divider, one quotient bit per cycle over
//   num_width(WINDOW) bits (21 at WINDOW 32). A new request is taken only
//   once the last result has moved into the output register.
// Stalls
//   The result sits in an output register; the next request is taken while it
//   waits. A further result is held internally until rsp_chan frees up.
// Reset
//   Synchronous, active high: no session, empty window, threshold 200.
//   The ring itself is not cleared; entries are read only once written.
// Depends on krg_pkg, krg_if, krg_ring, krg_div.
`default_nettype none

module keystroke_rate_guard #(
   parameter int unsigned WINDOW = krg_pkg::WINDOW_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   krg_req_if.sink                             req_chan,
   krg_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [krg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [krg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [krg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                           csr_pready
);
   import krg_pkg::*;

   localparam int unsigned AW    = $clog2(WINDOW);
   localparam int unsigned FW    = $clog2(WINDOW + 1);
   localparam int unsigned NUM_W = num_width(WINDOW);
   localparam int unsigned CW    = (NUM_W > WPM_W) ? NUM_W : WPM_W;

   state_type        state_ff, state_in;
   logic             session_ff, session_in;
   logic [AW-1:0]    slot_ff, slot_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [TIME_W-1:0] now_ff, now_in;
   rsp_type          res_ff, res_in;       // result waiting for the output stage
   rsp_type          out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   logic [WPM_W-1:0] max_ff;

   logic              ring_wr;
   logic              ring_rd;
   logic [AW-1:0]     slot_next;
   logic [TIME_W-1:0] oldest;
   logic [TIME_W-1:0] span;
   logic              div_start;
   div_stat_type      div_stat;
   logic [NUM_W-1:0]  div_q;
   logic [CW-1:0]     wpm_ext;
   logic              csr_wr;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= WPM_RESET;
      end else if (csr_wr && (csr_paddr[2] == CSR_MAX_WPM)) begin
         max_ff <= csr_pwdata[WPM_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_MAX_WPM) begin
         csr_prdata = CSR_DATA_W'(max_ff);
      end
   end

   // ---------------- datapath parts ----------------
   assign slot_next = (slot_ff == AW'(WINDOW - 1)) ? '0 : slot_ff + AW'(1);
   assign span      = now_ff - oldest;     // wraps mod 2^32
   assign wpm_ext   = CW'(div_q);

   krg_ring #(
      .WINDOW (WINDOW),
      .AW     (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (slot_ff),
      .wr_data (req_chan.key_time_ms),
      .rd_en   (ring_rd),
      .rd_addr (slot_next),
      .rd_data (oldest)
   );

   krg_div #(
      .WINDOW (WINDOW),
      .NUM_W  (NUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .span     (span),
      .stat     (div_stat),
      .quotient (div_q)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      session_in   = session_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      now_in       = now_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      ring_wr      = 1'b0;
      ring_rd      = 1'b0;
      div_start    = 1'b0;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               res_in   = '0;
               state_in = ST_HOLD;
               case (req_chan.req_type)
                  REQ_START: begin
                     session_in = 1'b1;
                     slot_in    = '0;
                     fill_in    = '0;
                     res_in.session_active = 1'b1;
                  end
                  REQ_END: begin
                     session_in = 1'b0;
                     res_in.session_active = 1'b0;
                  end
                  REQ_KEY: begin
                     res_in.session_active = session_ff;
                     if (session_ff) begin
                        ring_wr = 1'b1;
                        slot_in = slot_next;
                        now_in  = req_chan.key_time_ms;
                        if (fill_ff < FW'(WINDOW)) begin
                           fill_in = fill_ff + FW'(1);
                        end
                        // window full after this write: fetch the oldest time
                        if (fill_ff >= FW'(WINDOW - 1)) begin
                           ring_rd  = 1'b1;
                           state_in = ST_READ;
                        end
                     end
                  end
                  default: begin
                     res_in.session_active = session_ff;
                  end
               endcase
            end
         end
         ST_READ: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_in.rate_valid = 1'b1;
               res_in.rate_wpm   = (wpm_ext > CW'(WPM_MAX)) ? WPM_MAX
                                                            : wpm_ext[WPM_W-1:0];
               if (wpm_ext > CW'(max_ff)) begin
                  res_in.reject         = 1'b1;
                  res_in.session_active = 1'b0;
                  session_in            = 1'b0;
               end
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         session_ff   <= 1'b0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         session_ff   <= session_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
      now_ff <= now_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.rate_valid     = out_ff.rate_valid;
   assign rsp_chan.rate_wpm       = out_ff.rate_wpm;
   assign rsp_chan.reject         = out_ff.reject;
   assign rsp_chan.session_active = out_ff.session_active;

`ifndef ASSERT_OFF
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_DIV))
      else $error("divider busy outside divide state");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(WINDOW))
      else $error("fill count beyond window");

   a_read_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (fill_ff == FW'(WINDOW)))
      else $error("oldest time read before window full");

   a_reject_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD && res_ff.reject) |-> !session_ff)
      else $error("reject left session open");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.rate_valid) |-> (out_ff.rate_wpm == '0 && !out_ff.reject))
      else $error("rate fields set without rate estimate");
`endif

endmodule

`default_nettype wire

// File: rtl/krg_ring.sv
// Timestamp ring: one write port, one registered read port.
// Depends on krg_pkg.
`default_nettype none

module krg_ring #(
   parameter int unsigned WINDOW = krg_pkg::WINDOW_DEF,
   parameter int unsigned AW     = $clog2(WINDOW)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [krg_pkg::TIME_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output      logic [krg_pkg::TIME_W-1:0] rd_data
);
   import krg_pkg::*;

   logic [TIME_W-1:0] mem [WINDOW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/krg_div.sv
// Bit-serial restoring divider: WINDOW*60000 / (5*span), one quotient bit a cycle.
// Depends on krg_pkg.
`default_nettype none

module krg_div #(
   parameter int unsigned WINDOW = krg_pkg::WINDOW_DEF,
   parameter int unsigned NUM_W  = krg_pkg::num_width(WINDOW)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [krg_pkg::TIME_W-1:0]  span,
   output      krg_pkg::div_stat_type       stat,
   output      logic [NUM_W-1:0]            quotient
);
   import krg_pkg::*;

   localparam int unsigned DVS_W = TIME_W + 3;
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);
   localparam logic [NUM_W-1:0] DIVIDEND = NUM_W'(WINDOW * MS_PER_MIN);

   logic [NUM_W-1:0] num_ff, num_in;   // dividend bits out, quotient bits in
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [TIME_W-1:0] span_fix;
   logic [NUM_W:0]    rem_sh;
   logic [NUM_W:0]    rem_diff;
   logic              dvs_hi;
   logic              geq;

   always_comb begin
      span_fix = (span == '0) ? TIME_W'(1) : span;
      rem_sh   = {rem_ff, num_ff[NUM_W-1]};
      dvs_hi   = |(dvs_ff >> (NUM_W + 1));
      rem_diff = rem_sh - dvs_ff[NUM_W:0];
      geq      = !dvs_hi && (rem_sh >= dvs_ff[NUM_W:0]);

      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         num_in  = DIVIDEND;
         rem_in  = '0;
         dvs_in  = (DVS_W'(span_fix) << 2) + DVS_W'(span_fix);
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // partial remainder never exceeds the dividend, so NUM_W bits hold it
         rem_in = geq ? rem_diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
         num_in = {num_ff[NUM_W-2:0], geq};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = num_ff;

endmodule

`default_nettype wire

// File: dv/keystroke_rate_guard_tb.sv
// Self-checking testbench for keystroke_rate_guard: directed and random
// request traffic, predicted results checked against the result channel.
// Depends on krg_pkg, krg_if and the keystroke_rate_guard RTL.

module keystroke_rate_guard_tb;

   import krg_pkg::*;

   localparam int unsigned KEY_WINDOW   = WINDOW_DEF;
   localparam logic [1:0]  REQ_RESERVED = 2'd3;     // ignored by the block
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_WPM = {CSR_MAX_WPM, 2'b00};
   localparam int unsigned DRAIN_CYCLES = 40;       // about one divide plus output stalls
   localparam int unsigned QUIET_LIMIT  = 1000;     // cycles with no transfer at all
   localparam int unsigned RANDOM_ITEMS = 600;      // directed tests add about 300 more
   localparam int unsigned MAX_REPORTS  = 10;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   krg_req_if req_chan ();
   krg_rsp_if rsp_chan ();

   keystroke_rate_guard #(
      .WINDOW (KEY_WINDOW)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Rate predictor: its own copy of the keystroke ring, session and
   // threshold. Updated once per accepted request transfer.
   // ------------------------------------------------------------------
   logic [TIME_W-1:0] key_ring [KEY_WINDOW];
   int unsigned       ring_head;
   int unsigned       ring_fill;
   bit                session_open;
   logic [WPM_W-1:0]  wpm_limit;

   rsp_type     pending_verdicts [$];   // results still owed by the block
   int unsigned sent_items;             // every request transfer, ignored ones too
   int unsigned mismatch_count;
   int unsigned rsp_hold;               // cycles the result side still stalls
   int unsigned quiet;
   bit          no_idle;                // both sides run flat out while set

   function automatic rsp_type rate_verdict(input logic [1:0] code,
                                            input logic [TIME_W-1:0] stamp);
      rsp_type           verdict;
      logic [TIME_W-1:0] span;
      int unsigned       rate;
      verdict = '0;
      case (code)
         REQ_START: begin
            session_open = 1'b1;
            ring_head    = 0;
            ring_fill    = 0;
         end
         REQ_END: begin
            session_open = 1'b0;   // ring left as it stands
         end
         REQ_KEY: begin
            if (session_open) begin
               key_ring[ring_head] = stamp;
               ring_head = (ring_head + 1) % KEY_WINDOW;
               if (ring_fill < KEY_WINDOW)
                  ring_fill++;
               if (ring_fill == KEY_WINDOW) begin
                  // head now points at the oldest stored time; span wraps mod 2^32
                  span = stamp - key_ring[ring_head];
                  if (span == '0)
                     span = TIME_W'(1);
                  rate = (KEY_WINDOW * MS_PER_MIN / span) / CHARS_PER_WORD;
                  verdict.rate_valid = 1'b1;
                  verdict.rate_wpm   = (rate > WPM_MAX) ? WPM_MAX : rate[WPM_W-1:0];
                  if (rate > wpm_limit) begin
                     verdict.reject = 1'b1;
                     session_open   = 1'b0;
                  end
               end
            end
         end
         default: ;   // reserved code: no change
      endcase
      verdict.session_active = session_open;
      return verdict;
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t mismatch: %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------
   // Request side: one transfer per call. Valid stays high on return so
   // back-to-back items need no drop; settle() lowers it.
   // ------------------------------------------------------------------
   task automatic send_item(input logic [1:0] code, input logic [TIME_W-1:0] stamp);
      int unsigned pause;
      pause = no_idle ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (pause > 0) begin
         req_chan.valid = 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_chan.req_type    = code;
      req_chan.key_time_ms = stamp;
      req_chan.valid       = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      sent_items++;
      pending_verdicts.push_back(rate_verdict(code, stamp));
   endtask

   // Keystrokes at a fixed interval, wrapping freely.
   task automatic key_run(input logic [TIME_W-1:0] first, input logic [TIME_W-1:0] gap_ms,
                          input int unsigned count);
      logic [TIME_W-1:0] stamp;
      stamp = first;
      repeat (count) begin
         send_item(REQ_KEY, stamp);
         stamp += gap_ms;
      end
   endtask

   // Wait for every owed result, then give the block time to go quiet.
   task automatic settle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Threshold write followed by a read-back; only ever called once idle.
   task automatic write_threshold(input logic [WPM_W-1:0] value);
      settle();
      @(negedge clock);
      csr_psel   = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr  = ADDR_MAX_WPM;
      csr_pwdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      wpm_limit = value;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata[WPM_W-1:0] !== wpm_limit)
         log_mismatch($sformatf("max_human_wpm read back expected %0d got %0d",
                                wpm_limit, csr_prdata[WPM_W-1:0]));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Result side: ready stalls drawn per transfer, checking at each one.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_chan.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   rsp_type want;
   rsp_type seen;

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_hold = no_idle ? 0 : $urandom_range(0, 11);
         seen.rate_valid     = rsp_chan.rate_valid;
         seen.rate_wpm       = rsp_chan.rate_wpm;
         seen.reject         = rsp_chan.reject;
         seen.session_active = rsp_chan.session_active;
         if (pending_verdicts.size() == 0) begin
            log_mismatch($sformatf("unexpected result valid=%0d wpm=%0d reject=%0d active=%0d",
                                   seen.rate_valid, seen.rate_wpm, seen.reject,
                                   seen.session_active));
         end else begin
            want = pending_verdicts.pop_front();
            if (seen.rate_valid !== want.rate_valid || seen.rate_wpm !== want.rate_wpm ||
                seen.reject !== want.reject || seen.session_active !== want.session_active)
               log_mismatch($sformatf({"expected valid=%0d wpm=%0d reject=%0d active=%0d, ",
                                       "got valid=%0d wpm=%0d reject=%0d active=%0d"},
                                      want.rate_valid, want.rate_wpm, want.reject,
                                      want.session_active, seen.rate_valid, seen.rate_wpm,
                                      seen.reject, seen.session_active));
         end
      end
   end

   // Watchdog: any transfer on either channel or the register port resets it.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_psel && csr_penable)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("FAIL keystroke_rate_guard");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Keystrokes and ends with no session, reserved code in and out of one.
   task automatic test_without_session();
      send_item(REQ_KEY, '0);
      send_item(REQ_KEY, '1);
      send_item(REQ_END, 32'h5555_5555);
      send_item(REQ_RESERVED, 32'hAAAA_AAAA);
      send_item(REQ_START, '0);
      send_item(REQ_RESERVED, '1);
      send_item(REQ_KEY, 32'hAAAA_AAAA);
      send_item(REQ_END, '0);
      send_item(REQ_KEY, 32'h5555_5555);
   endtask

   // A start mid-session empties the ring, as does a start after an end.
   task automatic test_restart();
      send_item(REQ_START, '0);
      key_run(32'd1000, 32'd400, 20);
      send_item(REQ_START, '0);
      key_run(32'd20000, 32'd400, 31);            // one short of a full window
      key_run(32'd32400, 32'd400, 3);             // now rates at reset threshold
      send_item(REQ_END, '0);
      send_item(REQ_START, '1);
      key_run(32'd90000, 32'd400, 31);            // ring emptied: still no rate
      send_item(REQ_END, '1);
   endtask

   // All times equal: span read as 1 ms, the highest rate there is.
   task automatic test_zero_span();
      write_threshold(WPM_W'(384000));
      send_item(REQ_START, '0);
      key_run('1, '0, 34);                        // at the limit: no reject
      write_threshold(WPM_W'(383999));
      send_item(REQ_START, '0);
      key_run('0, '0, 33);                        // rejects, then the last is ignored
   endtask

   // Times running through the 32-bit wrap.
   task automatic test_wrap_span();
      write_threshold(WPM_RESET);
      send_item(REQ_START, '0);
      key_run(32'hFFFF_F000, 32'd700, 40);
      send_item(REQ_END, '0);
   endtask

   // Rate equal to the threshold passes, one above rejects; threshold zero.
   task automatic test_threshold_limit();
      no_idle = 1'b1;
      write_threshold(WPM_W'(41));               // 31 gaps of 300 ms give 41 wpm
      send_item(REQ_START, '0);
      key_run('0, 32'd300, 36);
      write_threshold(WPM_W'(40));               // session survives the write
      key_run(32'd10800, 32'd300, 2);
      no_idle = 1'b0;
      write_threshold('0);
      send_item(REQ_START, '0);
      key_run(32'd7, 32'd100000, 34);             // rate rounds to zero: passes
      send_item(REQ_START, '0);
      key_run('0, 32'd1000, 33);
   endtask

   // One session of random length and pace, with some noise around it.
   task automatic random_session();
      int unsigned       n_keys;
      int unsigned       pace;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] gap_ms;
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0:       send_item(REQ_RESERVED, $urandom());
            1:       send_item(REQ_KEY, $urandom());
            default: send_item(REQ_END, $urandom());
         endcase
      end
      send_item(REQ_START, $urandom());
      stamp  = $urandom();
      n_keys = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 31) : $urandom_range(32, 80);
      pace   = $urandom_range(0, 3);
      repeat (n_keys) begin
         case (pace)
            0:       gap_ms = $urandom_range(0, 40);          // machine speed
            1:       gap_ms = $urandom_range(100, 1500);      // human typing
            2:       gap_ms = $urandom_range(20000, 120000);  // rate near zero
            default: gap_ms = $urandom();
         endcase
         stamp += gap_ms;
         if ($urandom_range(0, 31) == 0)
            send_item(($urandom_range(0, 1) == 0) ? REQ_RESERVED : REQ_START, $urandom());
         send_item(REQ_KEY, stamp);
      end
      if ($urandom_range(0, 9) < 7)
         send_item(REQ_END, $urandom());
   endtask

   task automatic test_random_traffic();
      logic [WPM_W-1:0] limits [4];
      int unsigned      target;
      limits[0] = WPM_W'($urandom_range(10, 700));
      limits[1] = '0;
      limits[2] = WPM_W'(384000);
      limits[3] = WPM_W'($urandom_range(0, 384000));
      foreach (limits[p]) begin
         write_threshold(limits[p]);
         target = sent_items + RANDOM_ITEMS / 4;
         while (sent_items < target)
            random_session();
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_KEY;
      req_chan.key_time_ms = '0;
      rsp_chan.ready       = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      session_open         = 1'b0;
      ring_head            = 0;
      ring_fill            = 0;
      wpm_limit            = WPM_RESET;
      sent_items           = 0;
      mismatch_count       = 0;
      rsp_hold             = 0;
      quiet                = 0;
      no_idle              = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_without_session();
      test_restart();
      test_zero_span();
      test_wrap_span();
      test_threshold_limit();
      test_random_traffic();
      settle();

      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("PASS keystroke_rate_guard");
      else
         $display("FAIL keystroke_rate_guard");
      $finish;
   end

endmodule
